### rtl/core/gcab_pkg.sv
`default_nettype none

package gcab_pkg;

    // Item codes carried in the action field.
    typedef enum logic [1:0] {
        ACT_BLEND  = 2'd0,
        ACT_WR_DEC = 2'd1,
        ACT_WR_ENC = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_FG_RED   = 3'd0,
        CFG_FG_GREEN = 3'd1,
        CFG_FG_BLUE  = 3'd2,
        CFG_LINEAR   = 3'd3,
        CFG_SUBPIXEL = 3'd4
    } cfg_reg_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned NCHAN   = 3;
    localparam int unsigned LIN_W   = 12;
    localparam int unsigned IDX_W   = 12;
    localparam int unsigned SUM_W   = 20;
    localparam int unsigned DEC_AW  = 8;
    localparam int unsigned DEC_DEPTH = 256;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // Division by 255 as a multiply by ceil(2^28 / 255) and a shift. Exact for
    // every sum below 2^20, which covers 4095 * 255.
    localparam int unsigned DIV_RECIP_W = 21;
    localparam int unsigned DIV_SHIFT   = 28;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 21'd1052689;
    localparam int unsigned DIV_PROD_W  = SUM_W + DIV_RECIP_W;

    typedef struct packed {
        logic [1:0]        action;
        logic [IDX_W-1:0]  table_index;
        logic [LIN_W-1:0]  table_value;
        logic [CHAN_W-1:0] bg_red;
        logic [CHAN_W-1:0] bg_green;
        logic [CHAN_W-1:0] bg_blue;
        logic [CHAN_W-1:0] alpha_red;
        logic [CHAN_W-1:0] alpha_green;
        logic [CHAN_W-1:0] alpha_blue;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } out_item_t;

endpackage

`default_nettype wire

### rtl/core/gcab_ram.sv
`default_nettype none

// Single-port RAM with a registered read. A write cycle leaves the read data alone.
module gcab_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/glyph_coverage_alpha_blend.sv
`default_nettype none

// Blends the configured foreground color over one background RGB888 pixel per
// item, with per-channel coverage (or red coverage for all channels in grey
// mode): (fg*a + bg*(255-a))/255, truncated. In linear mode the colors pass
// through the decode table, are blended in linear light and are re-encoded
// through the encode table; software loads both tables with write items first.
// The block takes one item every cycle while the output is not stalled and
// returns a blend result through a three-stage pipeline of registered decode
// lookup, multiply-add, and reciprocal divide with encode lookup. Each table
// lookup has its own single-port memory copy, so the decode table is held six
// times and the encode table three times. Table writes and unused action codes
// return no result. The tables are not cleared by reset.
module glyph_coverage_alpha_blend #(
    parameter int unsigned LINEAR_MAX = 4095
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  gcab_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output gcab_pkg::out_item_t                  out_data,
    input  logic                                 cfg_we,
    input  logic [gcab_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gcab_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int unsigned ENC_DEPTH = LINEAR_MAX + 1;
    localparam int unsigned ENC_AW    = $clog2(ENC_DEPTH);
    localparam int unsigned CMP_W     = 17;
    localparam logic [CMP_W-1:0] LIN_LIMIT = CMP_W'(LINEAR_MAX);

    localparam int unsigned CW = gcab_pkg::CHAN_W;
    localparam int unsigned LW = gcab_pkg::LIN_W;
    localparam int unsigned NC = gcab_pkg::NCHAN;

    // Configuration registers.
    logic [CW-1:0] fg_reg [NC];
    logic          linear_reg;
    logic          subpixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg[0]    <= '0;
            fg_reg[1]    <= '0;
            fg_reg[2]    <= '0;
            linear_reg   <= 1'b0;
            subpixel_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (gcab_pkg::cfg_reg_t'(cfg_index))
                gcab_pkg::CFG_FG_RED:   fg_reg[0]    <= cfg_wdata;
                gcab_pkg::CFG_FG_GREEN: fg_reg[1]    <= cfg_wdata;
                gcab_pkg::CFG_FG_BLUE:  fg_reg[2]    <= cfg_wdata;
                gcab_pkg::CFG_LINEAR:   linear_reg   <= cfg_wdata[0];
                gcab_pkg::CFG_SUBPIXEL: subpixel_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Pipeline control: each stage moves when its successor is empty or moving.
    logic v1_reg, v2_reg, v3_reg;
    logic v1_next, v2_next, v3_next;
    logic ready1, ready2, ready3;
    logic in_acc, ld2, ld3;

    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;
    assign in_acc   = in_valid && ready1;
    assign ld2      = v1_reg && ready2;
    assign ld3      = v2_reg && ready3;

    logic in_blend, in_wr_dec, in_wr_enc;

    assign in_blend  = (in_data.action == gcab_pkg::ACT_BLEND);
    assign in_wr_dec = (in_data.action == gcab_pkg::ACT_WR_DEC);
    assign in_wr_enc = (in_data.action == gcab_pkg::ACT_WR_ENC);

    logic s1_blend_reg, s2_blend_reg;

    always_comb
    begin
        v1_next = ready1 ? (in_acc && (in_blend || in_wr_enc)) : v1_reg;
        v2_next = ready2 ? v1_reg : v2_reg;
        v3_next = ready3 ? (v2_reg && s2_blend_reg) : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Input stage: pick coverage and saturate an encode value.
    logic [CW-1:0] in_bg [NC];
    logic [CW-1:0] in_alpha [NC];
    logic [CW-1:0] in_enc_val;

    always_comb
    begin
        in_bg[0]    = in_data.bg_red;
        in_bg[1]    = in_data.bg_green;
        in_bg[2]    = in_data.bg_blue;
        in_alpha[0] = in_data.alpha_red;
        in_alpha[1] = subpixel_reg ? in_data.alpha_green : in_data.alpha_red;
        in_alpha[2] = subpixel_reg ? in_data.alpha_blue : in_data.alpha_red;
        if (in_data.table_value > LW'(gcab_pkg::CHAN_MAX))
        begin
            in_enc_val = gcab_pkg::CHAN_MAX;
        end
        else
        begin
            in_enc_val = in_data.table_value[CW-1:0];
        end
    end

    // Decode memories are read and written as the item is accepted.
    logic dec_idx_ok, dec_en;

    assign dec_idx_ok = (in_data.table_index[gcab_pkg::IDX_W-1:gcab_pkg::DEC_AW] == '0);
    assign dec_en     = in_acc && (in_blend || (in_wr_dec && dec_idx_ok));

    logic [LW-1:0] dec_bg_rd [NC];
    logic [LW-1:0] dec_fg_rd [NC];

    // Stage 1 registers.
    logic [CW-1:0]              s1_bg_reg [NC];
    logic [CW-1:0]              s1_alpha_reg [NC];
    logic [gcab_pkg::IDX_W-1:0] s1_idx_reg;
    logic [CW-1:0]              s1_val_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc && ready1)
        begin
            s1_blend_reg <= in_blend;
            s1_bg_reg    <= in_bg;
            s1_alpha_reg <= in_alpha;
            s1_idx_reg   <= in_data.table_index;
            s1_val_reg   <= in_enc_val;
        end
    end

    // Multiply-add per channel on encoded or decoded values.
    logic [gcab_pkg::SUM_W-1:0] sum_next [NC];
    logic [LW-1:0]              bg_op [NC];
    logic [LW-1:0]              fg_op [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            bg_op[c] = linear_reg ? dec_bg_rd[c] : LW'(s1_bg_reg[c]);
            fg_op[c] = linear_reg ? dec_fg_rd[c] : LW'(fg_reg[c]);
            sum_next[c] = gcab_pkg::SUM_W'(fg_op[c]) * gcab_pkg::SUM_W'(s1_alpha_reg[c])
                        + gcab_pkg::SUM_W'(bg_op[c])
                          * gcab_pkg::SUM_W'(gcab_pkg::CHAN_MAX - s1_alpha_reg[c]);
        end
    end

    // Stage 2 registers.
    logic [gcab_pkg::SUM_W-1:0] s2_sum_reg [NC];
    logic [gcab_pkg::IDX_W-1:0] s2_idx_reg;
    logic [CW-1:0]              s2_val_reg;

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_blend_reg <= s1_blend_reg;
            s2_sum_reg   <= sum_next;
            s2_idx_reg   <= s1_idx_reg;
            s2_val_reg   <= s1_val_reg;
        end
    end

    // Divide by 255, clamp to the linear range and address the encode memories.
    logic [gcab_pkg::DIV_PROD_W-1:0] div_prod [NC];
    logic [LW-1:0]                   quot [NC];
    logic [CMP_W-1:0]                lin_clamp [NC];
    logic [ENC_AW-1:0]               enc_addr [NC];
    logic                            enc_idx_ok, enc_en;

    assign enc_idx_ok = (CMP_W'(s2_idx_reg) <= LIN_LIMIT);
    assign enc_en     = ld3 && (s2_blend_reg || enc_idx_ok);

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            div_prod[c] = gcab_pkg::DIV_PROD_W'(s2_sum_reg[c])
                        * gcab_pkg::DIV_PROD_W'(gcab_pkg::DIV_RECIP);
            quot[c] = div_prod[c][gcab_pkg::DIV_SHIFT +: LW];
            if (CMP_W'(quot[c]) > LIN_LIMIT)
            begin
                lin_clamp[c] = LIN_LIMIT;
            end
            else
            begin
                lin_clamp[c] = CMP_W'(quot[c]);
            end
            enc_addr[c] = s2_blend_reg ? ENC_AW'(lin_clamp[c]) : ENC_AW'(s2_idx_reg);
        end
    end

    logic [CW-1:0] enc_rd [NC];

    // Per-channel copies of both tables.
    for (genvar c = 0; c < NC; c++)
    begin : g_chan
        gcab_ram #(
            .WIDTH (LW),
            .DEPTH (gcab_pkg::DEC_DEPTH)
        ) u_dec_bg (
            .clk   (clk),
            .en    (dec_en),
            .we    (in_wr_dec),
            .addr  (in_blend ? in_bg[c] : in_data.table_index[gcab_pkg::DEC_AW-1:0]),
            .wdata (in_data.table_value),
            .rdata (dec_bg_rd[c])
        );

        gcab_ram #(
            .WIDTH (LW),
            .DEPTH (gcab_pkg::DEC_DEPTH)
        ) u_dec_fg (
            .clk   (clk),
            .en    (dec_en),
            .we    (in_wr_dec),
            .addr  (in_blend ? fg_reg[c] : in_data.table_index[gcab_pkg::DEC_AW-1:0]),
            .wdata (in_data.table_value),
            .rdata (dec_fg_rd[c])
        );

        gcab_ram #(
            .WIDTH (CW),
            .DEPTH (ENC_DEPTH)
        ) u_enc (
            .clk   (clk),
            .en    (enc_en),
            .we    (!s2_blend_reg),
            .addr  (enc_addr[c]),
            .wdata (s2_val_reg),
            .rdata (enc_rd[c])
        );
    end

    // Stage 3 holds the plain quotient beside the encode lookup.
    logic [CW-1:0] s3_q_reg [NC];

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            for (int c = 0; c < NC; c++)
            begin
                s3_q_reg[c] <= quot[c][CW-1:0];
            end
        end
    end

    assign out_valid          = v3_reg;
    assign out_data.out_red   = linear_reg ? enc_rd[0] : s3_q_reg[0];
    assign out_data.out_green = linear_reg ? enc_rd[1] : s3_q_reg[1];
    assign out_data.out_blue  = linear_reg ? enc_rd[2] : s3_q_reg[2];

    // A decode table write or unused code never occupies the first stage.
    a_no_slot_for_dec_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_wr_dec || in_data.action == gcab_pkg::ACT_NONE)) |=> !v1_reg)
        else $error("decode write or unused code entered the pipeline");

    // An accepted blend sits in the first stage next cycle.
    a_blend_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_blend) |=> (v1_reg && s1_blend_reg))
        else $error("accepted blend item lost at stage 1");

    // A result appears only from a blend held in stage 2.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(v3_reg) |-> $past(v2_reg && s2_blend_reg))
        else $error("result raised without a blend in stage 2");

    // Input is held off only when the whole pipeline is full and blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
